// ===== sv/page_buffer_pool_replacement_assert.svh =====
// Assertion macros shared by the page buffer pool checker.
`ifndef PAGE_BUFFER_POOL_REPLACEMENT_ASSERT_SVH
`define PAGE_BUFFER_POOL_REPLACEMENT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/pbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pbp_pkg
// Types and constants for the page buffer pool frame table.
// ----------------------------------------------------------------------------
package pbp_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 24;
    localparam int PIN_W         = 16;
    localparam int STAMP_W       = 32;
    localparam int CNT_W         = 32;

    // Command codes.
    localparam logic [2:0] CMD_PIN      = 3'd0;
    localparam logic [2:0] CMD_UNPIN    = 3'd1;
    localparam logic [2:0] CMD_DIRTY    = 3'd2;
    localparam logic [2:0] CMD_FLUSH    = 3'd3;
    localparam logic [2:0] CMD_SHUTDOWN = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_LOADED   = 3'd1;
    localparam logic [2:0] ST_NO_FRAME = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_BUSY     = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    // Register indexes.
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_FLUSH_RD,
        S_FLUSH,
        S_CLEAR,
        S_OUT
    } state_t;

endpackage

// ===== sv/page_buffer_pool_replacement.sv =====
// Sequence: a command passes read setup, a scan of the frames in use frame by frame
// (stopping at the first match), decide and write; a flush sweep then reads, checks
// and outputs each frame in turn, and ends with the final result.
// Flow: one command at a time; s_tready returns in the cycle after the last result
// is taken.
// Reset: valid, pin and dirty bits clear, timer and counters zero, policy LRU, 8 frames.
// ----------------------------------------------------------------------------
// page_buffer_pool_replacement
// Frame table with pin, unpin, mark dirty, flush and shutdown commands,
// tag and stamp kept in a synchronous memory and swept frame by frame.
// ----------------------------------------------------------------------------
module page_buffer_pool_replacement
    import pbp_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: command[2:0], page_number[PAGE_BITS+2:3], zero fill
    input  logic [((PAGE_BITS+3+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status, frame, pin_count, load_page, write_back,
    // write_back_page, read_count, write_count from bit 0 up, zero fill
    output logic [((PAGE_BITS+3+3+PIN_W+2+2*CNT_W+7)/8)*8-1:0] m_tdata,
    output logic        m_tlast
);

    localparam int FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW   = $clog2(FRAMES + 1);
    localparam int MW   = PAGE_BITS + STAMP_W;
    localparam int OW   = ((PAGE_BITS + 3 + 3 + PIN_W + 2 + 2 * CNT_W + 7) / 8) * 8;

    // Configuration registers.
    logic       policy_reg;
    logic [3:0] frames_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b1;
            frames_reg <= 4'd8;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_POLICY)
                policy_reg <= pwdata[0];
            else
                frames_reg <= pwdata[3:0];
        end
    end
    assign prdata = (paddr[2] == REG_POLICY) ? {31'd0, policy_reg} : {28'd0, frames_reg};

    // Frames in use, clamped to one through FRAMES.
    logic [NW-1:0] n_act;
    always_comb
    begin
        if (frames_reg == 4'd0)
            n_act = NW'(1);
        else if (32'(frames_reg) > FRAMES)
            n_act = NW'(FRAMES);
        else
            n_act = NW'(frames_reg);
    end

    // Per frame flags in flip-flops, tag and stamp in memory.
    logic [FRAMES-1:0] valid_reg, dirty_reg;
    logic [PIN_W-1:0]  pins_reg [FRAMES];
    logic [MW-1:0]     mem [FRAMES];
    logic [MW-1:0]     rd_data;
    logic [FW-1:0]     rd_addr;
    logic              mem_we;
    logic [FW-1:0]     wr_addr;
    logic [MW-1:0]     wr_data;
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
    logic [PAGE_BITS-1:0] rd_tag;
    logic [STAMP_W-1:0]   rd_stamp;
    assign rd_tag   = rd_data[PAGE_BITS-1:0];
    assign rd_stamp = rd_data[MW-1:PAGE_BITS];

    // Control and working registers.
    state_t state_reg, state_next;
    logic [2:0]           cmd_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [NW-1:0]        idx_reg;   // read issue index
    logic [NW-1:0]        cur_reg;   // index whose data is on rd_data
    logic                 found_reg, hit_reg, vic_reg, ful_reg;
    logic [FW-1:0]        slot_reg, vidx_reg;
    logic [PAGE_BITS-1:0] vtag_reg;  // tag of the current victim
    logic [STAMP_W-1:0]   best_reg;
    logic [STAMP_W-1:0]   timer_reg;
    logic [CNT_W-1:0]     loads_reg, writes_reg;
    logic                 out_valid_reg, out_last_reg;
    logic [2:0]           o_status_reg, o_frame_reg;
    logic [PIN_W-1:0]     o_pins_reg;
    logic                 o_load_reg, o_wb_reg;
    logic [PAGE_BITS-1:0] o_wbpage_reg;
    logic                 ret_flush_reg; // after result, continue flush
    logic                 sd_reg;        // shutdown in progress

    logic [FW-1:0] cur_f;
    assign cur_f = cur_reg[FW-1:0];
    assign rd_addr = idx_reg[FW-1:0];

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OW'({writes_reg, loads_reg, o_wbpage_reg, o_wb_reg,
                          o_load_reg, o_pins_reg, o_frame_reg, o_status_reg});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid && s_tready)
                begin
                    if (s_tdata[2:0] == CMD_FLUSH || s_tdata[2:0] == CMD_SHUTDOWN
                        || s_tdata[2:0] == CMD_PIN || s_tdata[2:0] == CMD_UNPIN
                        || s_tdata[2:0] == CMD_DIRTY)
                        state_next = S_SCAN_RD;
                end
            S_SCAN_RD: state_next = S_SCAN;
            S_SCAN:
                if (found_reg || (idx_reg == n_act && cur_reg + NW'(1) == n_act))
                    state_next = S_DECIDE;
            S_DECIDE:  state_next = S_WRITE;
            S_WRITE:   state_next = S_OUT;
            S_FLUSH_RD: state_next = S_FLUSH;
            S_FLUSH:   state_next = S_OUT;
            S_CLEAR:   state_next = S_OUT;
            S_OUT:
                if (!out_valid_reg || m_tready)
                    state_next = ret_flush_reg ? S_FLUSH_RD : S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    logic [PIN_W-1:0] cp;
    logic             lru_hit;
    always_comb
    begin
        cp = pins_reg[slot_reg];
        lru_hit = policy_reg;
        mem_we  = (state_reg == S_WRITE) && cmd_reg == CMD_PIN && !ful_reg
                  && (!hit_reg || lru_hit);
        wr_addr = slot_reg;
        wr_data = hit_reg ? {timer_reg, page_reg} : {timer_reg, page_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            for (int i = 0; i < FRAMES; i++)
                pins_reg[i] <= '0;
            timer_reg     <= '0;
            loads_reg     <= '0;
            writes_reg    <= '0;
            out_valid_reg <= 1'b0;
            ret_flush_reg <= 1'b0;
            sd_reg        <= 1'b0;
            idx_reg       <= '0;
            cur_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    cmd_reg   <= s_tdata[2:0];
                    page_reg  <= s_tdata[PAGE_BITS+2:3];
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    hit_reg   <= 1'b0;
                    vic_reg   <= 1'b0;
                    ful_reg   <= 1'b0;
                    sd_reg    <= 1'b0;
                    slot_reg  <= '0;
                    ret_flush_reg <= 1'b0;
                end
                S_SCAN_RD:
                begin
                    // Issue the read of frame 0.
                    cur_reg <= idx_reg;
                    idx_reg <= idx_reg + NW'(1);
                end
                S_SCAN:
                begin
                    if (idx_reg != n_act)
                        idx_reg <= idx_reg + NW'(1);
                    cur_reg <= idx_reg;
                    // The first frame that qualifies is kept; a tie on victim stamp goes to the later frame.
                    if (!found_reg)
                    begin
                        case (cmd_reg)
                            CMD_PIN:
                            begin
                                if (!valid_reg[cur_f])
                                begin
                                    found_reg <= 1'b1;
                                    slot_reg  <= cur_f;
                                end
                                else if (rd_tag == page_reg)
                                begin
                                    found_reg <= 1'b1;
                                    hit_reg   <= 1'b1;
                                    slot_reg  <= cur_f;
                                end
                                else if (pins_reg[cur_f] == '0
                                         && (!vic_reg || rd_stamp <= best_reg))
                                begin
                                    vic_reg  <= 1'b1;
                                    best_reg <= rd_stamp;
                                    vidx_reg <= cur_f;
                                    vtag_reg <= rd_tag;
                                end
                            end
                            CMD_UNPIN, CMD_DIRTY:
                                if (valid_reg[cur_f] && rd_tag == page_reg)
                                begin
                                    found_reg <= 1'b1;
                                    hit_reg   <= 1'b1;
                                    slot_reg  <= cur_f;
                                end
                            CMD_SHUTDOWN:
                                if (pins_reg[cur_f] != '0)
                                begin
                                    found_reg <= 1'b1;
                                    hit_reg   <= 1'b1;
                                    slot_reg  <= cur_f;
                                end
                            default: ;
                        endcase
                    end
                end
                S_DECIDE:
                begin
                    if (cmd_reg == CMD_PIN && !found_reg)
                    begin
                        if (vic_reg)
                        begin
                            slot_reg <= vidx_reg;
                            idx_reg  <= NW'(vidx_reg);
                        end
                        else
                            ful_reg <= 1'b1;
                    end
                    else
                        idx_reg <= NW'(slot_reg);
                end
                S_WRITE:
                begin
                    // Flush and a shutdown that may proceed start the sweep instead.
                    out_valid_reg <= !(cmd_reg == CMD_FLUSH
                                       || (cmd_reg == CMD_SHUTDOWN && !hit_reg));
                    out_last_reg  <= 1'b1;
                    o_frame_reg   <= '0;
                    o_pins_reg    <= '0;
                    o_load_reg    <= 1'b0;
                    o_wb_reg      <= 1'b0;
                    o_wbpage_reg  <= '0;
                    case (cmd_reg)
                        CMD_PIN:
                            if (ful_reg)
                                o_status_reg <= ST_NO_FRAME;
                            else if (hit_reg)
                            begin
                                o_status_reg <= ST_HIT;
                                o_frame_reg  <= 3'(slot_reg);
                                o_pins_reg   <= cp;
                                if (cp != '1)
                                    pins_reg[slot_reg] <= cp + PIN_W'(1);
                                if (lru_hit)
                                    timer_reg <= timer_reg + STAMP_W'(1);
                            end
                            else
                            begin
                                o_status_reg <= ST_LOADED;
                                o_frame_reg  <= 3'(slot_reg);
                                o_pins_reg   <= cp;
                                o_load_reg   <= 1'b1;
                                if (valid_reg[slot_reg] && dirty_reg[slot_reg])
                                begin
                                    o_wb_reg     <= 1'b1;
                                    o_wbpage_reg <= vtag_reg;
                                    writes_reg   <= writes_reg + CNT_W'(1);
                                end
                                if (cp != '1)
                                    pins_reg[slot_reg] <= cp + PIN_W'(1);
                                valid_reg[slot_reg] <= 1'b1;
                                dirty_reg[slot_reg] <= 1'b0;
                                timer_reg <= timer_reg + STAMP_W'(1);
                                loads_reg <= loads_reg + CNT_W'(1);
                            end
                        CMD_UNPIN, CMD_DIRTY:
                            if (!hit_reg)
                                o_status_reg <= ST_ABSENT;
                            else
                            begin
                                o_status_reg <= ST_DONE;
                                o_frame_reg  <= 3'(slot_reg);
                                o_pins_reg   <= cp;
                                if (cmd_reg == CMD_DIRTY)
                                    dirty_reg[slot_reg] <= 1'b1;
                                else if (cp != '0)
                                    pins_reg[slot_reg] <= cp - PIN_W'(1);
                            end
                        CMD_SHUTDOWN:
                            if (hit_reg)
                            begin
                                o_status_reg <= ST_BUSY;
                                o_frame_reg  <= 3'(slot_reg);
                                o_pins_reg   <= cp;
                            end
                            else
                            begin
                                // Start the flush sweep, then empty the pool.
                                sd_reg        <= 1'b1;
                                ret_flush_reg <= 1'b1;
                                idx_reg       <= '0;
                            end
                        default:
                        begin
                            ret_flush_reg <= 1'b1;
                            idx_reg       <= '0;
                        end
                    endcase
                end
                S_FLUSH_RD:
                begin
                    cur_reg <= idx_reg;
                    idx_reg <= idx_reg + NW'(1);
                end
                S_FLUSH:
                begin
                    out_last_reg  <= 1'b0;
                    o_status_reg  <= ST_DONE;
                    o_pins_reg    <= '0;
                    o_load_reg    <= 1'b0;
                    if (cur_reg == n_act)
                    begin
                        // Final result of the sweep.
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= 1'b1;
                        o_frame_reg   <= '0;
                        o_wb_reg      <= 1'b0;
                        o_wbpage_reg  <= '0;
                        ret_flush_reg <= 1'b0;
                        if (sd_reg)
                            for (int i = 0; i < FRAMES; i++)
                                if (i < int'(n_act))
                                begin
                                    valid_reg[i] <= 1'b0;
                                    dirty_reg[i] <= 1'b0;
                                end
                    end
                    else if (valid_reg[cur_f] && dirty_reg[cur_f] && pins_reg[cur_f] == '0)
                    begin
                        out_valid_reg <= 1'b1;
                        o_frame_reg   <= 3'(cur_f);
                        o_wb_reg      <= 1'b1;
                        o_wbpage_reg  <= rd_tag;
                        dirty_reg[cur_f] <= 1'b0;
                        writes_reg    <= writes_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/pbp_checker.sv =====
// ----------------------------------------------------------------------------
// pbp_checker
// Port-level checks on the page buffer pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_buffer_pool_replacement_assert.svh"
module pbp_checker
    import pbp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast,
    input logic [2:0] m_status
);

    // No new item is taken while a result waits.
    `PBP_ASSERT_IMP(a_no_accept_busy, clk, rst_n, m_tvalid, !s_tready, "accept while result pending")
    // A stalled result holds.
    `PBP_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
    // Non-final results only come from flushing.
    `PBP_ASSERT_IMP(a_nonlast, clk, rst_n, m_tvalid && !m_tlast, m_status == ST_DONE, "bad partial")

endmodule

bind page_buffer_pool_replacement pbp_checker u_pbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_status (m_tdata[2:0])
);
